### rtl/etf_pkg.sv
// Package for the escape-time fractal unit.
// Holds the sequencer state type and the configuration register indexes.
// No dependencies.
`default_nettype none

package etf_pkg;

  localparam int CfgIdxBits = 3;

  typedef logic [CfgIdxBits-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FRACTAL_MODE     = 3'd0;
  localparam cfg_idx_t CFG_MAX_ITER         = 3'd1;
  localparam cfg_idx_t CFG_ESCAPE_RADIUS_SQ = 3'd2;
  localparam cfg_idx_t CFG_JULIA_CONST_RE   = 3'd3;
  localparam cfg_idx_t CFG_JULIA_CONST_IM   = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RR   = 6'b000010,
    S_II   = 6'b000100,
    S_RI   = 6'b001000,
    S_UPD  = 6'b010000,
    S_DONE = 6'b100000
  } etf_state_e;

endpackage

`default_nettype wire

### rtl/etf_point_if.sv
// Request channel carrying one complex point (signed Q4.28 by default).
// No dependencies.
`default_nettype none

interface etf_point_if #(
  parameter int COORD_BITS = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_re;
  logic signed [COORD_BITS-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

`default_nettype wire

### rtl/etf_result_if.sv
// Result channel carrying the iteration count and the escaped flag.
// No dependencies.
`default_nettype none

interface etf_result_if #(
  parameter int COUNT_BITS = 16
) ();
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] iteration_count;
  logic                  escaped;

  modport source (output valid, output iteration_count, output escaped, input ready);
  modport sink   (input valid, input iteration_count, input escaped, output ready);
endinterface

`default_nettype wire

### rtl/etf_mul.sv
// Shared signed multiplier with a registered product.
// No dependencies.
`default_nettype none

module etf_mul #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                           clk_i,
  input  wire logic signed [COORD_BITS-1:0]   a_i,
  input  wire logic signed [COORD_BITS-1:0]   b_i,
  output logic signed      [2*COORD_BITS-1:0] p_o
);

  logic signed [2*COORD_BITS-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*COORD_BITS)'(a_i) * (2*COORD_BITS)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/etf_core.sv
// Iteration sequencer and datapath for z = z^2 + c around one shared multiplier.
// Depends on etf_pkg and etf_mul.
`default_nettype none

module etf_core #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic signed [COORD_BITS-1:0] point_re_i,
  input  wire logic signed [COORD_BITS-1:0] point_im_i,
  input  wire logic                         mode_i,
  input  wire logic        [COUNT_BITS-1:0] max_iter_i,
  input  wire logic        [31:0]           esc_sq_i,
  input  wire logic signed [COORD_BITS-1:0] julia_re_i,
  input  wire logic signed [COORD_BITS-1:0] julia_im_i,
  output logic                              idle_o,
  output logic                              res_valid_o,
  input  wire logic                         res_take_i,
  output logic             [COUNT_BITS-1:0] res_count_o,
  output logic                              res_escaped_o
);

  import etf_pkg::*;

  localparam int W     = COORD_BITS;
  localparam int Frac  = W - 4;
  localparam int PW    = 2 * W;
  localparam int NW    = W + 6;
  localparam int CmpW  = (PW > 32 + Frac) ? PW : 32 + Frac;

  localparam logic signed [NW-1:0] CoordHi = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [NW-1:0] CoordLo = {{(NW-W+1){1'b1}}, {(W-1){1'b0}}};

  etf_state_e state_d, state_q;

  logic signed [W-1:0]  zr_q, zi_q, cr_q, ci_q;
  logic signed [PW-1:0] rr_q, diff_q;
  logic [COUNT_BITS-1:0] k_q;
  logic                  chk_q, esc_q;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [CmpW-1:0]      mag, limit;
  logic signed [NW-1:0] nr, ni;
  logic                 escape_hit, iter_end, sat;

  always_comb begin
    unique case (state_q)
      S_RR: begin
        mul_a = zr_q;
        mul_b = zr_q;
      end
      S_II: begin
        mul_a = zi_q;
        mul_b = zi_q;
      end
      default: begin
        mul_a = zr_q;
        mul_b = zi_q;
      end
    endcase
  end

  etf_mul #(
    .COORD_BITS(COORD_BITS)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign mag        = CmpW'($unsigned(rr_q)) + CmpW'($unsigned(prod));
  assign limit      = CmpW'({esc_sq_i, {Frac{1'b0}}});
  assign escape_hit = chk_q && (mag >= limit);
  assign iter_end   = chk_q && (k_q >= max_iter_i);

  assign nr  = NW'(diff_q >>> Frac) + NW'(cr_q);
  assign ni  = NW'(prod >>> (Frac - 1)) + NW'(ci_q);
  assign sat = (nr > CoordHi) || (nr < CoordLo) || (ni > CoordHi) || (ni < CoordLo);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = (esc_sq_i == 32'd0) ? S_DONE : S_RR;
        end
      end
      S_RR: state_d = S_II;
      S_II: state_d = S_RI;
      S_RI: state_d = (escape_hit || iter_end) ? S_DONE : S_UPD;
      S_UPD: state_d = sat ? S_DONE : S_RR;
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          k_q   <= '0;
          chk_q <= 1'b0;
          esc_q <= (esc_sq_i == 32'd0);
          if (mode_i) begin
            zr_q <= point_re_i;
            zi_q <= point_im_i;
            cr_q <= julia_re_i;
            ci_q <= julia_im_i;
          end else begin
            zr_q <= '0;
            zi_q <= '0;
            cr_q <= point_re_i;
            ci_q <= point_im_i;
          end
        end
      end
      S_II: rr_q <= prod;
      S_RI: begin
        diff_q <= rr_q - prod;
        if (escape_hit) begin
          esc_q <= 1'b1;
        end else if (chk_q && !iter_end) begin
          k_q <= k_q + COUNT_BITS'(1);
        end
      end
      S_UPD: begin
        if (sat) begin
          esc_q <= 1'b1;
        end else begin
          zr_q  <= nr[W-1:0];
          zi_q  <= ni[W-1:0];
          chk_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign idle_o        = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_DONE);
  assign res_count_o   = k_q;
  assign res_escaped_o = esc_q;

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_DONE && state_q != S_RR) |-> (k_q <= max_iter_i))
    else $error("iteration index past max_iter");

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && state_q == S_IDLE) |=> (state_q != S_IDLE))
    else $error("accepted point did not start work");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_take_i) |=>
      (state_q == S_DONE && $stable(k_q) && $stable(esc_q)))
    else $error("pending result changed before it was taken");

  a_bound_on_no_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !esc_q) |-> (k_q == max_iter_i))
    else $error("result without escape ended before max_iter");

endmodule

`default_nettype wire

### rtl/escape_time_fractal_unit.sv
// Escape-time fractal unit (Mandelbrot / Julia), signed Q4.28 coordinates.
// With escape_radius_sq 0 a point completes without iterating; else each iteration steps
// through S_RR, S_II, S_RI and S_UPD until escape, saturation or the count reaching max_iter.
// Only one request is in work at a time; the next is taken once the result enters the output register.
// Reset clears the registers to their defaults and empties the core and result stage.
// Depends on etf_pkg, etf_point_if, etf_result_if, etf_mul and etf_core.
`default_nettype none

module escape_time_fractal_unit #(
  parameter int COORD_BITS = 32,
  parameter int COUNT_BITS = 16,
  parameter int CFG_BITS   = (COORD_BITS > 32) ? COORD_BITS : 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  etf_point_if.sink                  point_i,
  etf_result_if.source               result_o,
  input  wire logic                  cfg_we_i,
  input  wire etf_pkg::cfg_idx_t     cfg_idx_i,
  input  wire logic [CFG_BITS-1:0]   cfg_wdata_i
);

  import etf_pkg::*;

  logic                         mode_q;
  logic [COUNT_BITS-1:0]        max_iter_q;
  logic [31:0]                  esc_sq_q;
  logic signed [COORD_BITS-1:0] julia_re_q, julia_im_q;

  logic                  core_idle, core_valid, core_take, core_esc, start;
  logic [COUNT_BITS-1:0] core_count;

  logic                  out_valid_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  out_esc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      max_iter_q <= COUNT_BITS'(255);
      esc_sq_q   <= 32'h4000_0000;
      julia_re_q <= '0;
      julia_im_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRACTAL_MODE:     mode_q     <= cfg_wdata_i[0];
        CFG_MAX_ITER:         max_iter_q <= cfg_wdata_i[COUNT_BITS-1:0];
        CFG_ESCAPE_RADIUS_SQ: esc_sq_q   <= cfg_wdata_i[31:0];
        CFG_JULIA_CONST_RE:   julia_re_q <= cfg_wdata_i[COORD_BITS-1:0];
        CFG_JULIA_CONST_IM:   julia_im_q <= cfg_wdata_i[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign point_i.ready = core_idle;
  assign start         = point_i.valid && core_idle;

  etf_core #(
    .COORD_BITS(COORD_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .point_re_i    (point_i.point_re),
    .point_im_i    (point_i.point_im),
    .mode_i        (mode_q),
    .max_iter_i    (max_iter_q),
    .esc_sq_i      (esc_sq_q),
    .julia_re_i    (julia_re_q),
    .julia_im_i    (julia_im_q),
    .idle_o        (core_idle),
    .res_valid_o   (core_valid),
    .res_take_i    (core_take),
    .res_count_o   (core_count),
    .res_escaped_o (core_esc)
  );

  assign core_take = core_valid && (!out_valid_q || result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_take) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take) begin
      out_count_q <= core_count;
      out_esc_q   <= core_esc;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.iteration_count = out_count_q;
  assign result_o.escaped         = out_esc_q;

endmodule

`default_nettype wire
